@@ sv/hcsc_pkg.sv @@
// ----------------------------------------------------------------------------
// hcsc_pkg: shared types, constants and helpers
// Codes, limits and small constant-divide helpers for the hall commutation
// speed controller.
// ----------------------------------------------------------------------------
package hcsc_pkg;

  localparam int AVG_DEPTH = 16;
  localparam int AVG_IDX_W = $clog2(AVG_DEPTH);
  localparam int AVG_SHIFT = $clog2(AVG_DEPTH);

  localparam int PERIOD_W = 9;
  localparam int SUM_W    = 13;
  localparam int OFF_W    = 7;
  localparam int DUTY_W   = 6;
  localparam int TGT_W    = 7;
  localparam int PWM_W    = 16;
  localparam int PROD_W   = PWM_W + DUTY_W;
  localparam int CFG_IDX_W = 2;

  localparam logic [PERIOD_W-1:0] STALL_TICKS = 9'd500;
  localparam logic [PERIOD_W-1:0] MIN_PERIOD  = 9'd9;
  localparam logic [PERIOD_W-1:0] MAX_PERIOD  = 9'd499;

  localparam logic [DUTY_W-1:0] DUTY_MAX      = 6'd50;
  localparam logic [DUTY_W-1:0] DUTY_MAX_M1   = 6'd49;
  localparam logic [DUTY_W-1:0] START_DUTY_RST = 6'd3;

  localparam logic [TGT_W-1:0] TARGET_LOW  = 7'd24;
  localparam logic [TGT_W-1:0] TARGET_HIGH = 7'd100;

  localparam logic [PWM_W-1:0] PWM_PERIOD_RST = 16'd110;
  localparam logic [7:0]       INTERVAL_RST   = 8'd80;

  // floor(x/100) = (x * RECIP_100) >> RECIP_SHIFT for any 22-bit x
  localparam int RECIP_SHIFT = 29;
  localparam logic [22:0] RECIP_100 = 23'd5368710;

  typedef enum logic [1:0] {
    KIND_TICK   = 2'd0,
    KIND_SLOWER = 2'd1,
    KIND_FASTER = 2'd2,
    KIND_SET    = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    DRIVE_OFF = 2'd0,
    DRIVE_FWD = 2'd1,
    DRIVE_REV = 2'd2
  } drive_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PWM_PERIOD      = 2'd0,
    CFG_START_DUTY      = 2'd1,
    CFG_CHANGE_INTERVAL = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic                enter;
    logic [PERIOD_W-1:0] period;
  } avg_req_t;

  typedef struct packed {
    logic [PERIOD_W-1:0] avg_q;
    logic [PERIOD_W-1:0] sw_q;
    logic [OFF_W-1:0]    off_q;
    logic [PERIOD_W-1:0] avg_d;
    logic [PERIOD_W-1:0] sw_d;
  } avg_stat_t;

  typedef struct packed {
    drive_e              drive;
    logic [DUTY_W-1:0]   duty;
    logic [PERIOD_W-1:0] avg;
    logic                fault;
  } res_t;

  // floor(x/5) for x < 128
  function automatic logic [4:0] div5(input logic [6:0] x);
    logic [14:0] p;
    p = 15'(x) * 15'd205;
    return p[14:10];
  endfunction

  // floor(x/25) for x < 512
  function automatic logic [4:0] div25(input logic [8:0] x);
    logic [18:0] p;
    p = 19'(x) * 19'd656;
    return p[18:14];
  endfunction

endpackage

@@ sv/hcsc_avg.sv @@
// ----------------------------------------------------------------------------
// hcsc_avg: period moving average and timing split
// Ring of the last hall periods with a running sum; derives the average,
// the switch time and the off time from it.
// ----------------------------------------------------------------------------
module hcsc_avg (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  hcsc_pkg::avg_req_t  req_i,
  output hcsc_pkg::avg_stat_t stat_o
);
  import hcsc_pkg::*;

  logic [PERIOD_W-1:0]  ring_q [AVG_DEPTH];
  logic [AVG_IDX_W-1:0] idx_q;
  logic [SUM_W-1:0]     sum_q, sum_d;
  logic [PERIOD_W-1:0]  avg_q, avg_d;
  logic [PERIOD_W-1:0]  sw_q, sw_d;
  logic [OFF_W-1:0]     off_q, off_d;

  logic [PERIOD_W-1:0] a;
  logic [5:0]          a6;
  logic [5:0]          lead;
  logic [OFF_W-1:0]    offt;
  logic [7:0]          a9;
  logic [9:0]          a23;

  always_comb begin
    sum_d = sum_q + SUM_W'(req_i.period) - SUM_W'(ring_q[idx_q]);
    a     = sum_d[SUM_W-1:AVG_SHIFT];
    a6    = a[5:0];
    a9    = 8'(a6) * 8'd9;
    a23   = 10'(a6) * 10'd23;
    if (a > 9'd35) begin
      lead = 6'd10;
      offt = 7'd10;
    end else if (a >= 9'd28) begin
      lead = 6'(div5(7'({a6, 1'b0})));
      offt = 7'(div5(7'(a6)));
    end else if (a >= 9'd24) begin
      lead = 6'(div5(7'(a9[7:2])));
      offt = 7'(div5(7'(a6)));
    end else begin
      lead = 6'(div25(a23[9:1]));
      offt = 7'(div5(7'(a6)));
    end
    avg_d = req_i.enter ? a : avg_q;
    off_d = req_i.enter ? offt : off_q;
    sw_d  = req_i.enter ? (a - PERIOD_W'(lead) - PERIOD_W'(offt)) : sw_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < AVG_DEPTH; i++) ring_q[i] <= '0;
      idx_q <= '0;
      sum_q <= '0;
      avg_q <= '0;
      sw_q  <= '0;
      off_q <= '0;
    end else if (req_i.enter) begin
      ring_q[idx_q] <= req_i.period;
      idx_q <= idx_q + AVG_IDX_W'(1);
      sum_q <= sum_d;
      avg_q <= avg_d;
      sw_q  <= sw_d;
      off_q <= off_d;
    end
  end

  assign stat_o.avg_q = avg_q;
  assign stat_o.sw_q  = sw_q;
  assign stat_o.off_q = off_q;
  assign stat_o.avg_d = avg_d;
  assign stat_o.sw_d  = sw_d;

endmodule

@@ sv/hcsc_core.sv @@
// ----------------------------------------------------------------------------
// hcsc_core: commutation and speed regulation state
// Tick counting, hall edge detection, duty regulation, target commands,
// drive state and stall fault; registers the per-transaction status.
// ----------------------------------------------------------------------------
module hcsc_core (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 step_en_i,
  input  hcsc_pkg::kind_e      kind_i,
  input  logic                 hall_i,
  input  logic [7:0]           target_i,
  input  logic [7:0]           interval_i,
  input  hcsc_pkg::avg_stat_t  avg_i,
  output hcsc_pkg::avg_req_t   avg_req_o,
  output hcsc_pkg::res_t       res_o
);
  import hcsc_pkg::*;

  logic [PERIOD_W-1:0] tick_q, tick_d, tc1;
  logic                hall_q, hall_d;
  logic [DUTY_W-1:0]   duty_q, duty_d;
  logic [7:0]          adj_q, adj_d;
  logic [TGT_W-1:0]    tgt_q, tgt_d;
  drive_e              drive_q, drive_d;
  logic                stall_q, stall_d;
  logic [9:0]          lim;
  logic                go_down, go_up;
  res_t                res_q;

  always_comb begin
    tick_d  = tick_q;
    hall_d  = hall_q;
    duty_d  = duty_q;
    adj_d   = adj_q;
    tgt_d   = tgt_q;
    drive_d = drive_q;
    stall_d = stall_q;
    tc1     = tick_q + PERIOD_W'(1);
    lim     = 10'(avg_i.sw_q) + 10'(avg_i.off_q);
    go_down = 1'b0;
    go_up   = 1'b0;
    avg_req_o.enter  = 1'b0;
    avg_req_o.period = tc1;
    if (step_en_i && !stall_q) begin
      unique case (kind_i)
        KIND_TICK: begin
          tick_d = tc1;
          if (hall_i != hall_q) begin
            tick_d = '0;
            if (tc1 >= MIN_PERIOD && tc1 <= MAX_PERIOD) begin
              avg_req_o.enter = 1'b1;
              hall_d = hall_i;
            end
            go_down = 10'(tgt_q) > 10'(avg_i.avg_d) + 10'd1;
            go_up   = 10'(tgt_q) + 10'd1 < 10'(avg_i.avg_d);
            if (go_down || go_up) begin
              if (adj_q > interval_i) begin
                adj_d = '0;
                if (go_up) duty_d = (duty_q < DUTY_MAX_M1) ? duty_q + DUTY_W'(1) : DUTY_MAX;
                else       duty_d = (duty_q > DUTY_W'(1)) ? duty_q - DUTY_W'(1) : '0;
              end else if (adj_q != 8'hff) begin
                adj_d = adj_q + 8'd1;
              end
            end
          end
          // switch time is the fresh one, the drive limit is from before the edge
          if (tick_d >= avg_i.sw_d && 10'(tick_d) < lim) drive_d = DRIVE_OFF;
          if (10'(tick_d) >= lim) begin
            if (duty_d > DUTY_MAX) drive_d = DRIVE_OFF;
            else                   drive_d = hall_d ? DRIVE_REV : DRIVE_FWD;
          end
          if (tick_d >= STALL_TICKS) begin
            stall_d = 1'b1;
            drive_d = DRIVE_OFF;
          end
        end
        KIND_SLOWER: tgt_d = (tgt_q < TARGET_HIGH) ? tgt_q + TGT_W'(1) : TARGET_HIGH;
        KIND_FASTER: tgt_d = (tgt_q > TARGET_LOW) ? tgt_q - TGT_W'(1) : TARGET_LOW;
        KIND_SET: begin
          if (target_i >= 8'(TARGET_LOW) && target_i <= 8'(TARGET_HIGH)) tgt_d = target_i[6:0];
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tick_q  <= '0;
      hall_q  <= 1'b0;
      duty_q  <= START_DUTY_RST;
      adj_q   <= '0;
      tgt_q   <= TARGET_HIGH;
      drive_q <= DRIVE_OFF;
      stall_q <= 1'b0;
    end else if (step_en_i) begin
      tick_q  <= tick_d;
      hall_q  <= hall_d;
      duty_q  <= duty_d;
      adj_q   <= adj_d;
      tgt_q   <= tgt_d;
      drive_q <= drive_d;
      stall_q <= stall_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step_en_i) begin
      res_q.drive <= drive_d;
      res_q.duty  <= duty_d;
      res_q.avg   <= avg_i.avg_d;
      res_q.fault <= stall_d;
    end
  end

  assign res_o = res_q;

endmodule

@@ sv/hcsc_cmp.sv @@
// ----------------------------------------------------------------------------
// hcsc_cmp: pwm compare scaling
// Two stages: pwm period times duty, then divide by one hundred through a
// reciprocal multiply; compare is zero while the bridge is off.
// ----------------------------------------------------------------------------
module hcsc_cmp (
  input  logic                           clk_i,
  input  logic                           load_c_i,
  input  logic                           load_d_i,
  input  logic [hcsc_pkg::PWM_W-1:0]     pwm_i,
  input  hcsc_pkg::res_t                 res_i,
  output hcsc_pkg::res_t                 res_o,
  output logic [hcsc_pkg::PWM_W-1:0]     cmp_o
);
  import hcsc_pkg::*;

  localparam int QW = PROD_W + 23;

  res_t              res_c_q, res_d_q;
  logic [PROD_W-1:0] prod_q;
  logic [PWM_W-1:0]  cmp_q, cmp_d;
  logic [QW-1:0]     quot;

  always_comb begin
    quot  = QW'(prod_q) * QW'(RECIP_100);
    cmp_d = (res_c_q.drive == DRIVE_OFF) ? '0 : quot[RECIP_SHIFT +: PWM_W];
  end

  always_ff @(posedge clk_i) begin
    if (load_c_i) begin
      res_c_q <= res_i;
      prod_q  <= PROD_W'(pwm_i) * PROD_W'(res_i.duty);
    end
    if (load_d_i) begin
      res_d_q <= res_c_q;
      cmp_q   <= cmp_d;
    end
  end

  assign res_o = res_d_q;
  assign cmp_o = cmp_q;

endmodule

@@ sv/hall_commutation_speed_controller.sv @@
// ----------------------------------------------------------------------------
// hall_commutation_speed_controller: hall sensor commutation and speed loop
// Tick and command transactions in, one status transaction out per input.
// ----------------------------------------------------------------------------
// Input channel: in_valid_i / in_stall_o with kind, hall level and target
// value. A tick advances the period counter and samples the hall level;
// the other kinds step or set the target period.
// Output channel: out_valid_o / out_stall_i with drive, compare value, duty,
// average period and fault, one transaction for every input transaction,
// in order.
// From acceptance a transaction passes the input register, the state update,
// the pwm product and the divide by one hundred feeding the output register.
// Throughput is one transaction per cycle while the receiver does not stall;
// the state loop closes combinationally around the state registers, and
// each stage refills as soon as the stage ahead moves.
// While the receiver stalls, the pipeline keeps filling empty stages and
// holds the waiting result unchanged.
// Reset clears the pipeline, restores register defaults, empties the period
// average and sets duty to its start value and the target period to 100.
// A start duty write is ignored; reset always applies the fixed start duty.
// ----------------------------------------------------------------------------
module hall_commutation_speed_controller (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [hcsc_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [hcsc_pkg::PWM_W-1:0]        cfg_data_i,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [1:0]                        kind_i,
  input  logic                              hall_level_i,
  input  logic [7:0]                        target_value_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [1:0]                        drive_o,
  output logic [hcsc_pkg::PWM_W-1:0]        compare_value_o,
  output logic [hcsc_pkg::DUTY_W-1:0]       duty_o,
  output logic [hcsc_pkg::PERIOD_W-1:0]     average_period_o,
  output logic                              fault_o
);
  import hcsc_pkg::*;

  logic [PWM_W-1:0] pwm_q;
  logic [7:0]       interval_q;

  logic       vld_a_q, vld_b_q, vld_c_q, vld_d_q;
  logic       rdy_a, rdy_b, rdy_c, rdy_d;
  kind_e      kind_a_q;
  logic       hall_a_q;
  logic [7:0] tgt_a_q;

  avg_req_t  avg_req;
  avg_stat_t avg_st;
  res_t      res_b, res_d;

  assign rdy_d = !vld_d_q || !out_stall_i;
  assign rdy_c = !vld_c_q || rdy_d;
  assign rdy_b = !vld_b_q || rdy_c;
  assign rdy_a = !vld_a_q || rdy_b;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pwm_q      <= PWM_PERIOD_RST;
      interval_q <= INTERVAL_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_PWM_PERIOD:      pwm_q      <= cfg_data_i;
        CFG_CHANGE_INTERVAL: interval_q <= cfg_data_i[7:0];
        CFG_START_DUTY:      ;
        default:             ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_a_q <= 1'b0;
      vld_b_q <= 1'b0;
      vld_c_q <= 1'b0;
      vld_d_q <= 1'b0;
    end else begin
      if (rdy_a) vld_a_q <= in_valid_i;
      if (rdy_b) vld_b_q <= vld_a_q;
      if (rdy_c) vld_c_q <= vld_b_q;
      if (rdy_d) vld_d_q <= vld_c_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && rdy_a) begin
      kind_a_q <= kind_e'(kind_i);
      hall_a_q <= hall_level_i;
      tgt_a_q  <= target_value_i;
    end
  end

  hcsc_avg u_avg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (avg_req),
    .stat_o (avg_st)
  );

  hcsc_core u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .step_en_i  (vld_a_q && rdy_b),
    .kind_i     (kind_a_q),
    .hall_i     (hall_a_q),
    .target_i   (tgt_a_q),
    .interval_i (interval_q),
    .avg_i      (avg_st),
    .avg_req_o  (avg_req),
    .res_o      (res_b)
  );

  hcsc_cmp u_cmp (
    .clk_i    (clk_i),
    .load_c_i (vld_b_q && rdy_c),
    .load_d_i (vld_c_q && rdy_d),
    .pwm_i    (pwm_q),
    .res_i    (res_b),
    .res_o    (res_d),
    .cmp_o    (compare_value_o)
  );

  assign in_stall_o       = !rdy_a;
  assign out_valid_o      = vld_d_q;
  assign drive_o          = res_d.drive;
  assign duty_o           = res_d.duty;
  assign average_period_o = res_d.avg;
  assign fault_o          = res_d.fault;

endmodule
